FILE: hw/rtl/tagged_value_stack_top_defines.svh
// Assertion macros used by the stack top module.
`ifndef TAGGED_VALUE_STACK_TOP_DEFINES_SVH
`define TAGGED_VALUE_STACK_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define TVS_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define TVS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/tvs_pkg.sv
package tvs_pkg;

  localparam int STACK_DEPTH_DEF  = 256;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int ACTION_W      = 3;
  localparam int TAG_W         = 4;
  localparam int PAYLOAD_PORT_W = 64;
  localparam int DEPTH_W       = 8;
  localparam int COUNT_PORT_W  = 9;
  localparam int IN_DATA_W     = 88;
  localparam int OUT_DATA_W    = 88;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_READ  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_DEPTH = 3'd2,
    ST_TYPE  = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

endpackage

FILE: hw/rtl/tagged_value_stack_top.sv
// Channel  Dir  Fields (lowest bit first)
// s_*      in   action, push_tag, push_payload, depth_from_top, expected_tag, check_type
// m_*      out  status, read_tag, read_payload, tag_matches, entry_count
//
// One item per cycle sustained unless stalled; each item waits in the s1 stage, then its
// result is loaded into the result register. The entry RAM is read at acceptance and its
// registered output feeds the result register; pushes write the RAM at acceptance.
// Reset empties the stack at once; no clearing pass is needed.
// A stalled result register holds the item in flight and stops acceptance.
`include "tagged_value_stack_top_defines.svh"

module tagged_value_stack_top #(
  parameter int STACK_DEPTH  = tvs_pkg::STACK_DEPTH_DEF,
  parameter int PAYLOAD_BITS = tvs_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // action[2:0], push_tag[6:3], push_payload[70:7], depth_from_top[78:71],
  // expected_tag[82:79], check_type[83], zero pad[87:84]
  input  logic [tvs_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[2:0], read_tag[6:3], read_payload[70:7], tag_matches[71],
  // entry_count[80:72], zero pad[87:81]
  output logic [tvs_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CMP_W  = (CNT_W > tvs_pkg::DEPTH_W) ? CNT_W : tvs_pkg::DEPTH_W;
  localparam int OCNT_W = (CNT_W > tvs_pkg::COUNT_PORT_W) ? CNT_W : tvs_pkg::COUNT_PORT_W;
  localparam int ENTRY_W = tvs_pkg::TAG_W + PAYLOAD_BITS;

  // Input fields.
  logic [tvs_pkg::ACTION_W-1:0]     in_action;
  logic [tvs_pkg::TAG_W-1:0]        in_push_tag;
  logic [tvs_pkg::PAYLOAD_PORT_W-1:0] in_push_payload;
  logic [tvs_pkg::DEPTH_W-1:0]      in_depth;
  logic [tvs_pkg::TAG_W-1:0]        in_expected_tag;
  logic                             in_check_type;

  assign in_action       = s_tdata[2:0];
  assign in_push_tag     = s_tdata[6:3];
  assign in_push_payload = s_tdata[70:7];
  assign in_depth        = s_tdata[78:71];
  assign in_expected_tag = s_tdata[82:79];
  assign in_check_type   = s_tdata[83];

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;

  // Item waiting for its RAM read.
  logic                      s1_valid;
  tvs_pkg::status_t          s1_status;
  logic                      s1_rd;
  logic                      s1_chk;
  logic [tvs_pkg::TAG_W-1:0] s1_etag;
  logic [tvs_pkg::COUNT_PORT_W-1:0] s1_count;

  // Result register.
  tvs_pkg::status_t                   out_status;
  logic [tvs_pkg::TAG_W-1:0]          out_tag;
  logic [tvs_pkg::PAYLOAD_PORT_W-1:0] out_payload;
  logic                               out_match;
  logic [tvs_pkg::COUNT_PORT_W-1:0]   out_count;

  logic accept;
  logic s1_adv;

  tvs_pkg::status_t   dec_status;
  logic               dec_rd;
  logic               dec_chk;
  logic               wr_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CMP_W-1:0]   fill_cmp;
  logic [CMP_W-1:0]   depth_cmp;
  logic [CMP_W-1:0]   depth_idx;
  logic [OCNT_W-1:0]  count_ext;
  logic [ENTRY_W-1:0] rd_entry;
  logic [tvs_pkg::TAG_W-1:0] rd_tag;
  logic [PAYLOAD_BITS-1:0]   rd_payload;
  logic               res_match;

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  assign fill_cmp  = CMP_W'(fill_count);
  assign depth_cmp = CMP_W'(in_depth);
  assign depth_idx = fill_cmp - CMP_W'(1) - depth_cmp;
  assign count_ext = OCNT_W'(fill_count_next);

  always_comb begin
    fill_count_next = fill_count;
    dec_status      = tvs_pkg::ST_OK;
    dec_rd          = 1'b0;
    dec_chk         = 1'b0;
    wr_en           = 1'b0;
    rd_addr         = ADDR_W'(fill_cmp - CMP_W'(1));
    unique case (in_action)
      tvs_pkg::ACT_PUSH: begin
        if (fill_count >= CNT_W'(STACK_DEPTH)) begin
          dec_status = tvs_pkg::ST_FULL;
        end else begin
          wr_en           = accept;
          fill_count_next = fill_count + CNT_W'(1);
        end
      end
      tvs_pkg::ACT_POP: begin
        if (fill_count == '0) begin
          dec_status = tvs_pkg::ST_EMPTY;
        end else begin
          fill_count_next = fill_count - CNT_W'(1);
        end
      end
      tvs_pkg::ACT_PEEK: begin
        if (fill_count == '0) begin
          dec_status = tvs_pkg::ST_EMPTY;
        end else begin
          dec_rd = 1'b1;
        end
      end
      tvs_pkg::ACT_CLEAR: begin
        fill_count_next = '0;
      end
      tvs_pkg::ACT_READ: begin
        if (depth_cmp >= fill_cmp) begin
          dec_status = tvs_pkg::ST_DEPTH;
        end else begin
          dec_rd  = 1'b1;
          dec_chk = in_check_type;
          rd_addr = depth_idx[ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  tvs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_count[ADDR_W-1:0]),
    .wr_data ({in_push_tag, in_push_payload[PAYLOAD_BITS-1:0]}),
    .rd_en   (accept && dec_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  assign rd_tag     = rd_entry[ENTRY_W-1:PAYLOAD_BITS];
  assign rd_payload = rd_entry[PAYLOAD_BITS-1:0];
  assign res_match  = s1_rd && (rd_tag == s1_etag);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      s1_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        fill_count <= fill_count_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= dec_status;
      s1_rd     <= dec_rd;
      s1_chk    <= dec_chk;
      s1_etag   <= in_expected_tag;
      s1_count  <= count_ext[tvs_pkg::COUNT_PORT_W-1:0];
    end
    if (s1_adv) begin
      // A failed type check still reports the entry that was read.
      out_status  <= (s1_chk && !res_match) ? tvs_pkg::ST_TYPE : s1_status;
      out_tag     <= s1_rd ? rd_tag : '0;
      out_payload <= s1_rd ? tvs_pkg::PAYLOAD_PORT_W'(rd_payload) : '0;
      out_match   <= res_match;
      out_count   <= s1_count;
    end
  end

  assign m_tdata = {7'd0, out_count, out_match, out_payload, out_tag, out_status};

  `TVS_ASSERT_NEXT(a_push_grows, clk, rst,
    accept && (in_action == tvs_pkg::ACT_PUSH) && (fill_count < CNT_W'(STACK_DEPTH)),
    fill_count == $past(fill_count) + CNT_W'(1), "push did not grow the stack")
  `TVS_ASSERT_NEXT(a_clear_empties, clk, rst,
    accept && (in_action == tvs_pkg::ACT_CLEAR),
    fill_count == '0, "clear did not empty the stack")
  `TVS_ASSERT_SAME(a_stall_blocks, clk, rst,
    s1_valid && m_tvalid && !m_tready,
    !s_tready, "item accepted while the pipeline is stalled")
  `TVS_ASSERT_SAME(a_fail_no_data, clk, rst,
    m_tvalid && ((out_status == tvs_pkg::ST_DEPTH) || (out_status == tvs_pkg::ST_EMPTY)),
    (out_tag == '0) && (out_payload == '0) && !out_match,
    "failed read reports entry data")
  `TVS_ASSERT_SAME(a_fill_bound, clk, rst,
    1'b1, fill_count <= CNT_W'(STACK_DEPTH), "fill count beyond stack depth")

endmodule

FILE: hw/rtl/tvs_ram.sv
module tvs_ram #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sim/tagged_value_stack_checker.sv
module tagged_value_stack_checker
  import tvs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // action[2:0], push_tag[6:3], push_payload[70:7], depth_from_top[78:71],
  // expected_tag[82:79], check_type[83], zero pad[87:84]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // status[2:0], read_tag[6:3], read_payload[70:7], tag_matches[71],
  // entry_count[80:72], zero pad[87:81]
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    errors,
  output int                    pending,
  output int                    items_in,
  output int                    results_out,
  output int                    full_hits,
  output int                    empty_hits,
  output int                    range_hits,
  output int                    type_hits
);

  localparam int DEPTH = STACK_DEPTH_DEF;

  typedef struct packed {
    status_t                   status;
    logic [TAG_W-1:0]          tag;
    logic [PAYLOAD_PORT_W-1:0] payload;
    logic                      match;
    logic [COUNT_PORT_W-1:0]   count;
  } stack_result_t;

  logic [TAG_W-1:0]          shadow_tag [DEPTH];
  logic [PAYLOAD_PORT_W-1:0] shadow_payload [DEPTH];
  int unsigned               fill_level = 0;
  stack_result_t             pending_stack_results [$];

  int n_fail = 0;
  int n_items = 0;
  int n_results = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_range = 0;
  int n_type = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
             n_results, what, got, want);
    n_fail++;
  endtask

  // Applies one accepted item to the shadow stack and returns its result.
  task automatic apply_stack_op(input logic [IN_DATA_W-1:0] d, output stack_result_t r);
    logic [ACTION_W-1:0]       act;
    logic [TAG_W-1:0]          ptag;
    logic [PAYLOAD_PORT_W-1:0] ppay;
    logic [DEPTH_W-1:0]        dep;
    logic [TAG_W-1:0]          etag;
    logic                      chk;
    int unsigned               idx;
    act  = d[2:0];
    ptag = d[6:3];
    ppay = d[70:7];
    dep  = d[78:71];
    etag = d[82:79];
    chk  = d[83];
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (fill_level >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_tag[fill_level] = ptag;
          shadow_payload[fill_level] = ppay;
          fill_level++;
        end
      end
      ACT_POP: begin
        if (fill_level == 0) r.status = ST_EMPTY;
        else fill_level--;
      end
      ACT_PEEK: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          idx = fill_level - 1;
          r.tag = shadow_tag[idx];
          r.payload = shadow_payload[idx];
          r.match = (shadow_tag[idx] == etag);
        end
      end
      ACT_CLEAR: fill_level = 0;
      ACT_READ: begin
        if (dep >= fill_level) begin
          r.status = ST_DEPTH;
        end else begin
          idx = fill_level - 1 - dep;
          r.tag = shadow_tag[idx];
          r.payload = shadow_payload[idx];
          r.match = (shadow_tag[idx] == etag);
          if (chk && !r.match) r.status = ST_TYPE;
        end
      end
      default: ;
    endcase
    r.count = fill_level[COUNT_PORT_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    stack_result_t want;
    stack_result_t got;
    if (rst) begin
      fill_level = 0;
      pending_stack_results.delete();
    end else begin
      // The result leaving now always belongs to an older item than the one
      // entering, so it is compared before the new expectation is queued.
      if (m_tvalid && m_tready) begin
        n_results++;
        got.status  = status_t'(m_tdata[2:0]);
        got.tag     = m_tdata[6:3];
        got.payload = m_tdata[70:7];
        got.match   = m_tdata[71];
        got.count   = m_tdata[80:72];
        if (pending_stack_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", m_tdata[63:0], '0);
        end else begin
          want = pending_stack_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.tag !== want.tag)
            report_mismatch("read_tag", got.tag, want.tag);
          if (got.payload !== want.payload)
            report_mismatch("read_payload", got.payload, want.payload);
          if (got.match !== want.match)
            report_mismatch("tag_matches", got.match, want.match);
          if (got.count !== want.count)
            report_mismatch("entry_count", got.count, want.count);
        end
      end
      if (s_tvalid && s_tready) begin
        n_items++;
        apply_stack_op(s_tdata, want);
        pending_stack_results.push_back(want);
        case (want.status)
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          ST_DEPTH: n_range++;
          ST_TYPE:  n_type++;
          default: ;
        endcase
      end
    end
    errors      <= n_fail;
    pending     <= pending_stack_results.size();
    items_in    <= n_items;
    results_out <= n_results;
    full_hits   <= n_full;
    empty_hits  <= n_empty;
    range_hits  <= n_range;
    type_hits   <= n_type;
  end

endmodule

FILE: sim/tb.sv
module tb;
  import tvs_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam logic [PAYLOAD_PORT_W-1:0] ALL_ONES = '1;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // action[2:0], push_tag[6:3], push_payload[70:7], depth_from_top[78:71],
  // expected_tag[82:79], check_type[83], zero pad[87:84]
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // status[2:0], read_tag[6:3], read_payload[70:7], tag_matches[71],
  // entry_count[80:72], zero pad[87:81]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  steady = 1'b0;

  int errors, pending, items_in, results_out;
  int full_hits, empty_hits, range_hits, type_hits;
  int quiet_cycles = 0;

  tagged_value_stack_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  tagged_value_stack_checker stack_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .pending     (pending),
    .items_in    (items_in),
    .results_out (results_out),
    .full_hits   (full_hits),
    .empty_hits  (empty_hits),
    .range_hits  (range_hits),
    .type_hits   (type_hits)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("No handshake for %0d cycles", quiet_cycles);
        $display("tagged_value_stack_top test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(input logic [ACTION_W-1:0] act, input logic [TAG_W-1:0] tag,
                         input logic [PAYLOAD_PORT_W-1:0] pay, input logic [DEPTH_W-1:0] dep,
                         input logic [TAG_W-1:0] etag, input logic chk);
    while (!steady && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, chk, etag, dep, pay, tag, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int                        sent;
    int                        seg_len;
    int                        mode;
    int                        span;
    int                        r;
    logic [ACTION_W-1:0]       act;
    logic [PAYLOAD_PORT_W-1:0] pay;
    logic [DEPTH_W-1:0]        dep;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-stack errors, spare actions, tag extremes, type checks, reads past size and clears.
    send_op(ACT_POP,   4'd0,  '0, 8'd0, 4'd0, 1'b0);
    send_op(ACT_PEEK,  4'd0,  '0, 8'd0, 4'd0, 1'b1);
    send_op(ACT_READ,  4'd0,  '0, 8'd0, 4'd0, 1'b1);
    send_op(ACT_SPARE_LO,        4'd15, ALL_ONES, 8'd255, 4'd15, 1'b1);
    send_op(ACT_SPARE_LO + 3'd1, 4'd3,  '0, 8'd7, 4'd2, 1'b0);
    send_op(ACT_SPARE_HI,        4'd0,  ALL_ONES, 8'd0, 4'd0, 1'b1);
    send_op(ACT_PUSH,  4'd0,  '0, 8'd0, 4'd0, 1'b0);
    send_op(ACT_PUSH,  4'd15, ALL_ONES, 8'd255, 4'd15, 1'b1);
    send_op(ACT_PUSH,  4'd12, 64'h5555_5555_5555_5555, 8'd0, 4'd0, 1'b0);
    send_op(ACT_PEEK,  4'd0,  '0, 8'd0, 4'd12, 1'b0);
    send_op(ACT_PEEK,  4'd0,  '0, 8'd0, 4'd0, 1'b1);
    send_op(ACT_READ,  4'd0,  '0, 8'd0, 4'd12, 1'b1);
    send_op(ACT_READ,  4'd0,  '0, 8'd0, 4'd3, 1'b1);
    send_op(ACT_READ,  4'd0,  '0, 8'd2, 4'd0, 1'b0);
    send_op(ACT_READ,  4'd0,  '0, 8'd1, 4'd15, 1'b1);
    send_op(ACT_READ,  4'd0,  '0, 8'd3, 4'd0, 1'b0);
    send_op(ACT_READ,  4'd0,  '0, 8'd255, 4'd0, 1'b1);
    send_op(ACT_POP,   4'd0,  '0, 8'd0, 4'd0, 1'b0);
    send_op(ACT_CLEAR, 4'd0,  '0, 8'd0, 4'd0, 1'b0);
    send_op(ACT_POP,   4'd0,  '0, 8'd0, 4'd0, 1'b0);
    send_op(ACT_READ,  4'd0,  '0, 8'd0, 4'd0, 1'b0);
    send_op(ACT_PUSH,  4'd13, 64'hAAAA_AAAA_AAAA_AAAA, 8'd0, 4'd0, 1'b0);
    send_op(ACT_PEEK,  4'd0,  '0, 8'd0, 4'd13, 1'b1);
    send_op(ACT_CLEAR, 4'd0,  '0, 8'd0, 4'd0, 1'b0);

    // Random segments. The first one fills the stack so that pushes hit full.
    sent = 0;
    mode = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len = (mode <= 2) ? 300 : $urandom_range(20, 120);
      // A narrow tag range makes tag matches common; the wide one covers all codes.
      span = $urandom_range(0, 1) ? 15 : 3;
      for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
        steady <= (sent >= 700 && sent < 1000);
        r = $urandom_range(0, 99);
        if (mode <= 2) begin
          act = (r < 92) ? ACT_PUSH
                         : ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end else if (mode <= 4) begin
          act = (r < 75) ? ACT_POP : (r < 85) ? ACT_PEEK : (r < 95) ? ACT_READ : ACT_PUSH;
        end else begin
          if (r < 35) act = ACT_PUSH;
          else if (r < 55) act = ACT_POP;
          else if (r < 68) act = ACT_PEEK;
          else if (r < 93) act = ACT_READ;
          else if (r < 95) act = ACT_CLEAR;
          else act = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end
        r = $urandom_range(0, 99);
        pay = (r < 5) ? ALL_ONES : (r < 10) ? '0 : {$urandom, $urandom};
        dep = ($urandom_range(0, 99) < 70) ? DEPTH_W'($urandom_range(0, 15))
                                           : DEPTH_W'($urandom_range(0, 255));
        send_op(act, TAG_W'($urandom_range(0, span)), pay, dep,
                TAG_W'($urandom_range(0, span)), 1'($urandom_range(0, 1)));
        sent++;
      end
      mode = $urandom_range(0, 9);
      if (mode == 9) begin
        send_op(ACT_CLEAR, TAG_W'($urandom), {$urandom, $urandom}, DEPTH_W'($urandom),
                TAG_W'($urandom), 1'($urandom));
        sent++;
      end
    end
    s_tvalid <= 1'b0;
    steady <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("Run covered %0d items and %0d checked results across fill, drain and mixed use.",
             items_in, results_out);
    $display("Refused pushes %0d, empty pops or peeks %0d, reads past size %0d, type errors %0d.",
             full_hits, empty_hits, range_hits, type_hits);
    if (errors == 0) begin
      $display("tagged_value_stack_top test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tagged_value_stack_top test failed");
    end
    $finish;
  end

endmodule
